// ===== rtl/crtcvt_pkg.sv =====
// ----------------------------------------------------------------------------
// crtcvt_pkg
// shared types and codes for the crt controller timing generator
// ----------------------------------------------------------------------------
package crtcvt_pkg;

    // request kinds
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // bus port select
    localparam logic [1:0] PORT_INDEX   = 2'd0;
    localparam logic [1:0] PORT_DATA_WR = 2'd1;
    localparam logic [1:0] PORT_STATUS  = 2'd2;
    localparam logic [1:0] PORT_DATA_RD = 2'd3;

    // register indexes
    localparam logic [7:0] REG_H_TOTAL     = 8'd0;
    localparam logic [7:0] REG_H_DISPLAYED = 8'd1;
    localparam logic [7:0] REG_H_SYNC_POS  = 8'd2;
    localparam logic [7:0] REG_SYNC_WIDTH  = 8'd3;
    localparam logic [7:0] REG_V_TOTAL     = 8'd4;
    localparam logic [7:0] REG_V_ADJUST    = 8'd5;
    localparam logic [7:0] REG_V_DISPLAYED = 8'd6;
    localparam logic [7:0] REG_V_SYNC_POS  = 8'd7;
    localparam logic [7:0] REG_SKEW        = 8'd8;
    localparam logic [7:0] REG_MAX_RASTER  = 8'd9;
    localparam logic [7:0] REG_START_HI    = 8'd12;
    localparam logic [7:0] REG_START_LO    = 8'd13;

    // reset values
    localparam logic [7:0] RST_H_TOTAL      = 8'd63;
    localparam logic [7:0] RST_H_DISPLAYED  = 8'd40;
    localparam logic [7:0] RST_H_SYNC_POS   = 8'd46;
    localparam logic [3:0] RST_H_SYNC_WIDTH = 4'd14;
    localparam logic [4:0] RST_V_SYNC_WIDTH = 5'd8;
    localparam logic [6:0] RST_V_TOTAL      = 7'd38;
    localparam logic [6:0] RST_V_DISPLAYED  = 7'd25;
    localparam logic [6:0] RST_V_SYNC_POS   = 7'd30;
    localparam logic [7:0] RST_MAX_RASTER   = 8'd7;

    // vertical sync width code 0 stands for this many lines
    localparam logic [4:0] V_SYNC_WIDTH_MAX = 5'd16;

    typedef struct packed {
        logic [7:0]  h_total;
        logic [7:0]  h_displayed;
        logic [7:0]  h_sync_pos;
        logic [3:0]  h_sync_width;
        logic [4:0]  v_sync_width;
        logic [6:0]  v_total;
        logic [4:0]  v_adjust;
        logic [6:0]  v_displayed;
        logic [6:0]  v_sync_pos;
        logic [7:0]  max_raster;
        logic [13:0] start_addr;
    } t_cfg;

    typedef struct packed {
        logic        hsync;
        logic        vsync;
        logic        border;
        logic [15:0] mem_addr;
        logic [4:0]  raster_addr;
    } t_video;

    typedef struct packed {
        t_video     video;
        logic [7:0] read_data;
    } t_result;

endpackage

// ===== rtl/crtcvt_regs.sv =====
// ----------------------------------------------------------------------------
// crtcvt_regs
// index register, timing register file and bus read mux
// ----------------------------------------------------------------------------
module crtcvt_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_req_type,
    input  logic [1:0]          i_port,
    input  logic [7:0]          i_write_data,
    output crtcvt_pkg::t_cfg    o_cfg,
    output logic [7:0]          o_read_data
);

    logic [7:0]       r_index;
    logic [7:0]       r_skew;
    crtcvt_pkg::t_cfg r_cfg;
    logic [7:0]       n_index;
    logic [7:0]       n_skew;
    crtcvt_pkg::t_cfg n_cfg;
    logic             w_idx_wr;
    logic             w_data_wr;
    logic             w_data_rd;

    assign w_idx_wr  = i_accept && (i_req_type == crtcvt_pkg::REQ_WRITE)
                       && (i_port == crtcvt_pkg::PORT_INDEX);
    assign w_data_wr = i_accept && (i_req_type == crtcvt_pkg::REQ_WRITE)
                       && (i_port == crtcvt_pkg::PORT_DATA_WR);
    assign w_data_rd = (i_req_type == crtcvt_pkg::REQ_READ)
                       && (i_port == crtcvt_pkg::PORT_DATA_RD);

    always_comb begin
        n_index = r_index;
        n_skew  = r_skew;
        n_cfg   = r_cfg;
        if (w_idx_wr) begin
            n_index = i_write_data;
        end
        if (w_data_wr) begin
            case (r_index)
                crtcvt_pkg::REG_H_TOTAL:     n_cfg.h_total     = i_write_data;
                crtcvt_pkg::REG_H_DISPLAYED: n_cfg.h_displayed = i_write_data;
                crtcvt_pkg::REG_H_SYNC_POS:  n_cfg.h_sync_pos  = i_write_data;
                crtcvt_pkg::REG_SYNC_WIDTH: begin
                    n_cfg.h_sync_width = i_write_data[3:0];
                    if (i_write_data[7:4] == 4'd0) begin
                        n_cfg.v_sync_width = crtcvt_pkg::V_SYNC_WIDTH_MAX;
                    end else begin
                        n_cfg.v_sync_width = {1'b0, i_write_data[7:4]};
                    end
                end
                crtcvt_pkg::REG_V_TOTAL:     n_cfg.v_total     = i_write_data[6:0];
                crtcvt_pkg::REG_V_ADJUST:    n_cfg.v_adjust    = i_write_data[4:0];
                crtcvt_pkg::REG_V_DISPLAYED: n_cfg.v_displayed = i_write_data[6:0];
                crtcvt_pkg::REG_V_SYNC_POS:  n_cfg.v_sync_pos  = i_write_data[6:0];
                crtcvt_pkg::REG_SKEW:        n_skew            = i_write_data;
                crtcvt_pkg::REG_MAX_RASTER:  n_cfg.max_raster  = i_write_data;
                crtcvt_pkg::REG_START_HI:
                    n_cfg.start_addr[13:8] = i_write_data[5:0];
                crtcvt_pkg::REG_START_LO:
                    n_cfg.start_addr[7:0]  = i_write_data;
                default: ;
            endcase
        end
    end

    // read mux, only on a data-port read
    always_comb begin
        o_read_data = 8'd0;
        if (w_data_rd) begin
            case (r_index)
                crtcvt_pkg::REG_H_TOTAL:     o_read_data = r_cfg.h_total;
                crtcvt_pkg::REG_H_DISPLAYED: o_read_data = r_cfg.h_displayed;
                crtcvt_pkg::REG_H_SYNC_POS:  o_read_data = r_cfg.h_sync_pos;
                crtcvt_pkg::REG_SYNC_WIDTH:
                    o_read_data = {r_cfg.v_sync_width[3:0], r_cfg.h_sync_width};
                crtcvt_pkg::REG_V_TOTAL:     o_read_data = {1'b0, r_cfg.v_total};
                crtcvt_pkg::REG_V_ADJUST:    o_read_data = {3'd0, r_cfg.v_adjust};
                crtcvt_pkg::REG_V_DISPLAYED: o_read_data = {1'b0, r_cfg.v_displayed};
                crtcvt_pkg::REG_V_SYNC_POS:  o_read_data = {1'b0, r_cfg.v_sync_pos};
                crtcvt_pkg::REG_SKEW:        o_read_data = r_skew;
                crtcvt_pkg::REG_MAX_RASTER:  o_read_data = r_cfg.max_raster;
                crtcvt_pkg::REG_START_HI:
                    o_read_data = {2'd0, r_cfg.start_addr[13:8]};
                crtcvt_pkg::REG_START_LO:    o_read_data = r_cfg.start_addr[7:0];
                default:                     o_read_data = 8'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index            <= 8'd0;
            r_skew             <= 8'd0;
            r_cfg.h_total      <= crtcvt_pkg::RST_H_TOTAL;
            r_cfg.h_displayed  <= crtcvt_pkg::RST_H_DISPLAYED;
            r_cfg.h_sync_pos   <= crtcvt_pkg::RST_H_SYNC_POS;
            r_cfg.h_sync_width <= crtcvt_pkg::RST_H_SYNC_WIDTH;
            r_cfg.v_sync_width <= crtcvt_pkg::RST_V_SYNC_WIDTH;
            r_cfg.v_total      <= crtcvt_pkg::RST_V_TOTAL;
            r_cfg.v_adjust     <= 5'd0;
            r_cfg.v_displayed  <= crtcvt_pkg::RST_V_DISPLAYED;
            r_cfg.v_sync_pos   <= crtcvt_pkg::RST_V_SYNC_POS;
            r_cfg.max_raster   <= crtcvt_pkg::RST_MAX_RASTER;
            r_cfg.start_addr   <= 14'd0;
        end else begin
            r_index <= n_index;
            r_skew  <= n_skew;
            r_cfg   <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/crtcvt_timing.sv =====
// ----------------------------------------------------------------------------
// crtcvt_timing
// horizontal, raster and vertical counters, sync pulses and address counter
// ----------------------------------------------------------------------------
module crtcvt_timing (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tick,
    input  crtcvt_pkg::t_cfg    i_cfg,
    output crtcvt_pkg::t_video  o_video
);

    logic [7:0]  r_hc,  n_hc;
    logic [7:0]  r_hsc, n_hsc;
    logic [6:0]  r_vc,  n_vc;
    logic [3:0]  r_vsc, n_vsc;
    logic [4:0]  r_raster, n_raster;
    logic [15:0] r_addr, n_addr;
    logic [15:0] r_rba,  n_rba;
    logic        r_hs, n_hs;
    logic        r_vs, n_vs;
    logic        r_hdisp, n_hdisp;
    logic        r_vdisp, n_vdisp;
    logic        r_adjust, n_adjust;
    logic        r_border, n_border;
    logic [15:0] w_start;

    assign w_start = {2'b00, i_cfg.start_addr};

    // one character clock worth of counter updates
    always_comb begin
        n_hc     = r_hc;
        n_hsc    = r_hsc;
        n_vc     = r_vc;
        n_vsc    = r_vsc;
        n_raster = r_raster;
        n_addr   = r_addr;
        n_rba    = r_rba;
        n_hs     = r_hs;
        n_vs     = r_vs;
        n_hdisp  = r_hdisp;
        n_vdisp  = r_vdisp;
        n_adjust = r_adjust;

        if (r_hs) begin
            n_hsc = r_hsc + 8'd1;
            if (n_hsc == {4'd0, i_cfg.h_sync_width}) begin
                n_hs = 1'b0;
            end
        end
        if (r_hdisp && r_vdisp) begin
            n_addr = r_addr + 16'd1;
        end

        if (r_hc == i_cfg.h_total) begin
            // end of line
            n_hc    = 8'd0;
            n_hdisp = 1'b1;
            if (r_vs) begin
                n_vsc = r_vsc + 4'd1;
                if (({1'b0, n_vsc} == i_cfg.v_sync_width) || (n_vsc == 4'd0)) begin
                    n_vs = 1'b0;
                end
            end
            if (r_adjust) begin
                n_raster = r_raster + 5'd1;
                if (n_raster == i_cfg.v_adjust) begin
                    n_vdisp  = 1'b1;
                    n_addr   = w_start;
                    n_rba    = w_start;
                    n_adjust = 1'b0;
                    n_raster = 5'd0;
                end else begin
                    n_addr = r_rba;
                end
            end else if ({3'd0, r_raster} == i_cfg.max_raster) begin
                // end of character row
                n_raster = 5'd0;
                n_rba    = n_addr;
                if (r_vc == i_cfg.v_total) begin
                    n_vc = 7'd0;
                    if (i_cfg.v_adjust == 5'd0) begin
                        n_vdisp = 1'b1;
                        n_addr  = w_start;
                        n_rba   = w_start;
                    end else begin
                        n_adjust = 1'b1;
                    end
                end else begin
                    n_vc = r_vc + 7'd1;
                end
                if (n_vc == i_cfg.v_displayed) begin
                    n_vdisp = 1'b0;
                end
                if (n_vc == i_cfg.v_sync_pos) begin
                    n_vs  = 1'b1;
                    n_vsc = 4'd0;
                end
            end else begin
                n_raster = r_raster + 5'd1;
                n_addr   = r_rba;
            end
        end else begin
            n_hc = r_hc + 8'd1;
        end

        if (n_hc == i_cfg.h_displayed) begin
            n_hdisp = 1'b0;
        end
        if (n_hc == i_cfg.h_sync_pos) begin
            n_hs  = 1'b1;
            n_hsc = 8'd0;
        end
        n_border = !(n_hdisp && n_vdisp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc     <= 8'd0;
            r_hsc    <= 8'd0;
            r_vc     <= 7'd0;
            r_vsc    <= 4'd0;
            r_raster <= 5'd0;
            r_addr   <= 16'd0;
            r_rba    <= 16'd0;
            r_hs     <= 1'b0;
            r_vs     <= 1'b0;
            r_hdisp  <= 1'b0;
            r_vdisp  <= 1'b0;
            r_adjust <= 1'b0;
            r_border <= 1'b0;
        end else if (i_tick) begin
            r_hc     <= n_hc;
            r_hsc    <= n_hsc;
            r_vc     <= n_vc;
            r_vsc    <= n_vsc;
            r_raster <= n_raster;
            r_addr   <= n_addr;
            r_rba    <= n_rba;
            r_hs     <= n_hs;
            r_vs     <= n_vs;
            r_hdisp  <= n_hdisp;
            r_vdisp  <= n_vdisp;
            r_adjust <= n_adjust;
            r_border <= n_border;
        end
    end

    // levels as they stand after the current request
    always_comb begin
        if (i_tick) begin
            o_video.hsync       = n_hs;
            o_video.vsync       = n_vs;
            o_video.border      = n_border;
            o_video.mem_addr    = n_addr;
            o_video.raster_addr = n_raster;
        end else begin
            o_video.hsync       = r_hs;
            o_video.vsync       = r_vs;
            o_video.border      = r_border;
            o_video.mem_addr    = r_addr;
            o_video.raster_addr = r_raster;
        end
    end

endmodule

// ===== rtl/crtc_video_timing_top.sv =====
// ----------------------------------------------------------------------------
// crtc_video_timing_top
// crt controller timing generator with bus register access
// ----------------------------------------------------------------------------
// Each request is a character clock tick or a bus access (index write, data
// write, data read). The block takes one request per clock while o_in_ready
// is high: the counter and register update for a request is a single
// combinational pass from the current state, and the result (sync levels,
// border, memory address, raster address, read data) is registered in the
// output entry, or parked in the skid entry while the output stalls. The
// output side is a two-entry skid buffer, so o_in_ready is a register and
// drops only when the output has stalled with both entries full; with
// i_out_ready held high the rate is one request per cycle. Bus accesses never
// move the counters; a status read and a read of an unmapped register
// return 0.
// ----------------------------------------------------------------------------
module crtc_video_timing_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_port,
    input  logic [7:0]  i_write_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_hsync,
    output logic        o_vsync,
    output logic        o_border,
    output logic [15:0] o_mem_addr,
    output logic [4:0]  o_raster_addr,
    output logic [7:0]  o_read_data
);

    logic                  w_accept;
    logic                  w_tick;
    crtcvt_pkg::t_cfg      w_cfg;
    crtcvt_pkg::t_video    w_video;
    logic [7:0]            w_read_data;
    crtcvt_pkg::t_result   w_res;

    // output register and skid entry
    crtcvt_pkg::t_result   r_out,  n_out;
    crtcvt_pkg::t_result   r_skid, n_skid;
    logic                  r_out_valid,  n_out_valid;
    logic                  r_skid_valid, n_skid_valid;

    assign o_in_ready = !r_skid_valid;
    assign w_accept   = i_in_valid && !r_skid_valid;
    assign w_tick     = w_accept && (i_req_type == crtcvt_pkg::REQ_TICK);

    // register file and bus decode
    crtcvt_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_req_type   (i_req_type),
        .i_port       (i_port),
        .i_write_data (i_write_data),
        .o_cfg        (w_cfg),
        .o_read_data  (w_read_data)
    );

    // counters, only stepped by ticks
    crtcvt_timing u_timing (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (w_tick),
        .i_cfg   (w_cfg),
        .o_video (w_video)
    );

    assign w_res.video     = w_video;
    assign w_res.read_data = w_read_data;

    // skid buffer control
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || i_out_ready) begin
            // output slot free or drained this cycle
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = w_res;
                n_out_valid = w_accept;
            end
        end else if (w_accept) begin
            // output stalled, park the new result
            n_skid       = w_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid   = r_out_valid;
    assign o_hsync       = r_out.video.hsync;
    assign o_vsync       = r_out.video.vsync;
    assign o_border      = r_out.video.border;
    assign o_mem_addr    = r_out.video.mem_addr;
    assign o_raster_addr = r_out.video.raster_addr;
    assign o_read_data   = r_out.read_data;

    // skid entry only fills behind a held output entry
    a_skid_behind_out: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid
    ) else $error("skid entry valid while output entry empty");

    // a draining output always empties the skid entry
    a_skid_drains: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_ready) |=> !r_skid_valid
    ) else $error("skid entry not drained");

    // nonzero read data only comes from a data-port read
    a_read_source: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_read_data != 8'd0)) |->
            ((i_req_type == crtcvt_pkg::REQ_READ) && (i_port == crtcvt_pkg::PORT_DATA_RD))
    ) else $error("read data produced without a data read");

endmodule

// ===== dv/crtc_video_timing_top_tb.sv =====
// ----------------------------------------------------------------------------
// crtc_video_timing_top_tb
// self-checking testbench for the crt controller timing generator
// ----------------------------------------------------------------------------
// Runs a short table of directed requests first: reset read-back, ignored
// ports, unknown request kind, unmapped index, sync width codes and wrapping
// registers. A random phase follows that reprograms the timing registers to
// small values so that lines, rows, adjust lines and both sync pulses turn
// over often, mixed with read-backs, noise requests and bursts of ticks. Typed
// rows are held to their want, all else to a cycle-accurate timing model here.
// ----------------------------------------------------------------------------
module crtc_video_timing_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // request kind that the block does not know, must change nothing
    localparam logic [1:0] REQ_UNKNOWN  = 2'd3;
    // an index that maps to no register
    localparam logic [7:0] REG_UNMAPPED = 8'hFF;

    localparam int unsigned RANDOM_REQUESTS = 1850;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned DRAIN_CYCLES    = 20;
    localparam int unsigned MAX_WAIT        = 18;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_req_type;
    logic [1:0]  i_port;
    logic [7:0]  i_write_data;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_hsync;
    logic        o_vsync;
    logic        o_border;
    logic [15:0] o_mem_addr;
    logic [4:0]  o_raster_addr;
    logic [7:0]  o_read_data;

    crtc_video_timing_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_port        (i_port),
        .i_write_data  (i_write_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_hsync       (o_hsync),
        .o_vsync       (o_vsync),
        .o_border      (o_border),
        .o_mem_addr    (o_mem_addr),
        .o_raster_addr (o_raster_addr),
        .o_read_data   (o_read_data)
    );

    // one row of the directed table; want is used only when typed is set
    typedef struct {
        logic [1:0]          req;
        logic [1:0]          port;
        logic [7:0]          data;
        bit                  typed;
        crtcvt_pkg::t_result want;
    } t_bus_row;

    // ------------------------------------------------------------------------
    // timing model state
    // ------------------------------------------------------------------------
    crtcvt_pkg::t_cfg tim_cfg;
    logic [7:0]  sel_index;
    logic [7:0]  skew_value;        // register 8, stored and read back only
    logic [7:0]  char_cnt;
    logic [7:0]  hsync_len;
    logic [6:0]  row_cnt;
    logic [3:0]  vsync_len;
    logic [4:0]  scan_line;
    logic [15:0] video_addr;
    logic [15:0] row_start;
    logic        hsync_on;
    logic        vsync_on;
    logic        hdisp_on;
    logic        vdisp_on;
    logic        in_adjust;
    logic        border_on;

    crtcvt_pkg::t_result predicted_results[$];
    t_bus_row    directed_rows[$];
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned requests_sent;
    bit          quiet_stretch;     // both sides run without gaps while set

    // ------------------------------------------------------------------------
    // clock, cycle limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, predicted_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // timing model
    // ------------------------------------------------------------------------
    function automatic void model_reset();
        tim_cfg              = '0;
        tim_cfg.h_total      = crtcvt_pkg::RST_H_TOTAL;
        tim_cfg.h_displayed  = crtcvt_pkg::RST_H_DISPLAYED;
        tim_cfg.h_sync_pos   = crtcvt_pkg::RST_H_SYNC_POS;
        tim_cfg.h_sync_width = crtcvt_pkg::RST_H_SYNC_WIDTH;
        tim_cfg.v_sync_width = crtcvt_pkg::RST_V_SYNC_WIDTH;
        tim_cfg.v_total      = crtcvt_pkg::RST_V_TOTAL;
        tim_cfg.v_displayed  = crtcvt_pkg::RST_V_DISPLAYED;
        tim_cfg.v_sync_pos   = crtcvt_pkg::RST_V_SYNC_POS;
        tim_cfg.max_raster   = crtcvt_pkg::RST_MAX_RASTER;
        sel_index  = '0;
        skew_value = '0;
        char_cnt   = '0;
        hsync_len  = '0;
        row_cnt    = '0;
        vsync_len  = '0;
        scan_line  = '0;
        video_addr = '0;
        row_start  = '0;
        hsync_on   = 1'b0;
        vsync_on   = 1'b0;
        hdisp_on   = 1'b0;
        vdisp_on   = 1'b0;
        in_adjust  = 1'b0;
        border_on  = 1'b0;
    endfunction

    // top of frame: display on, address back to the start register
    function automatic void restart_frame();
        vdisp_on   = 1'b1;
        video_addr = {2'b00, tim_cfg.start_addr};
        row_start  = video_addr;
    endfunction

    // one character clock: horizontal first, then line and row turnover
    function automatic void char_tick();
        if (hsync_on) begin
            hsync_len = hsync_len + 8'd1;
            if (hsync_len == {4'd0, tim_cfg.h_sync_width})
                hsync_on = 1'b0;
        end
        if (hdisp_on && vdisp_on)
            video_addr = video_addr + 16'd1;
        if (char_cnt == tim_cfg.h_total) begin
            char_cnt = '0;
            hdisp_on = 1'b1;
            // vertical sync counts lines, 4-bit counter wrap ends a 16-line pulse
            if (vsync_on) begin
                vsync_len = vsync_len + 4'd1;
                if ({1'b0, vsync_len} == tim_cfg.v_sync_width || vsync_len == 4'd0)
                    vsync_on = 1'b0;
            end
            if (in_adjust) begin
                scan_line = scan_line + 5'd1;
                if (scan_line == tim_cfg.v_adjust) begin
                    restart_frame();
                    in_adjust = 1'b0;
                    scan_line = '0;
                end else begin
                    video_addr = row_start;
                end
            end else if ({3'd0, scan_line} == tim_cfg.max_raster) begin
                scan_line = '0;
                row_start = video_addr;
                if (row_cnt == tim_cfg.v_total) begin
                    row_cnt = '0;
                    if (tim_cfg.v_adjust == 5'd0)
                        restart_frame();
                    else
                        in_adjust = 1'b1;
                end else begin
                    row_cnt = row_cnt + 7'd1;
                end
                if (row_cnt == tim_cfg.v_displayed)
                    vdisp_on = 1'b0;
                if (row_cnt == tim_cfg.v_sync_pos) begin
                    vsync_on  = 1'b1;
                    vsync_len = '0;
                end
            end else begin
                scan_line  = scan_line + 5'd1;
                video_addr = row_start;
            end
        end else begin
            char_cnt = char_cnt + 8'd1;
        end
        if (char_cnt == tim_cfg.h_displayed)
            hdisp_on = 1'b0;
        if (char_cnt == tim_cfg.h_sync_pos) begin
            hsync_on  = 1'b1;
            hsync_len = '0;
        end
        border_on = !(hdisp_on && vdisp_on);
    endfunction

    // applies one request to the model and returns the levels after it
    function automatic crtcvt_pkg::t_result crtc_timing_step(input logic [1:0] req,
                                                             input logic [1:0] port,
                                                             input logic [7:0] data);
        crtcvt_pkg::t_result res;
        res = '0;
        case (req)
            crtcvt_pkg::REQ_TICK: char_tick();
            crtcvt_pkg::REQ_WRITE: begin
                if (port == crtcvt_pkg::PORT_INDEX) begin
                    sel_index = data;
                end else if (port == crtcvt_pkg::PORT_DATA_WR) begin
                    case (sel_index)
                        crtcvt_pkg::REG_H_TOTAL:     tim_cfg.h_total     = data;
                        crtcvt_pkg::REG_H_DISPLAYED: tim_cfg.h_displayed = data;
                        crtcvt_pkg::REG_H_SYNC_POS:  tim_cfg.h_sync_pos  = data;
                        crtcvt_pkg::REG_SYNC_WIDTH: begin
                            tim_cfg.h_sync_width = data[3:0];
                            // width code 0 stands for the longest pulse
                            tim_cfg.v_sync_width = (data[7:4] == 4'd0) ?
                                                   crtcvt_pkg::V_SYNC_WIDTH_MAX :
                                                   {1'b0, data[7:4]};
                        end
                        crtcvt_pkg::REG_V_TOTAL:     tim_cfg.v_total     = data[6:0];
                        crtcvt_pkg::REG_V_ADJUST:    tim_cfg.v_adjust    = data[4:0];
                        crtcvt_pkg::REG_V_DISPLAYED: tim_cfg.v_displayed = data[6:0];
                        crtcvt_pkg::REG_V_SYNC_POS:  tim_cfg.v_sync_pos  = data[6:0];
                        crtcvt_pkg::REG_SKEW:        skew_value          = data;
                        crtcvt_pkg::REG_MAX_RASTER:  tim_cfg.max_raster  = data;
                        crtcvt_pkg::REG_START_HI:    tim_cfg.start_addr[13:8] = data[5:0];
                        crtcvt_pkg::REG_START_LO:    tim_cfg.start_addr[7:0]  = data;
                        default: ;
                    endcase
                end
            end
            crtcvt_pkg::REQ_READ: begin
                if (port == crtcvt_pkg::PORT_DATA_RD) begin
                    case (sel_index)
                        crtcvt_pkg::REG_H_TOTAL:     res.read_data = tim_cfg.h_total;
                        crtcvt_pkg::REG_H_DISPLAYED: res.read_data = tim_cfg.h_displayed;
                        crtcvt_pkg::REG_H_SYNC_POS:  res.read_data = tim_cfg.h_sync_pos;
                        crtcvt_pkg::REG_SYNC_WIDTH:
                            res.read_data = {tim_cfg.v_sync_width[3:0],
                                             tim_cfg.h_sync_width};
                        crtcvt_pkg::REG_V_TOTAL:
                            res.read_data = {1'b0, tim_cfg.v_total};
                        crtcvt_pkg::REG_V_ADJUST:
                            res.read_data = {3'd0, tim_cfg.v_adjust};
                        crtcvt_pkg::REG_V_DISPLAYED:
                            res.read_data = {1'b0, tim_cfg.v_displayed};
                        crtcvt_pkg::REG_V_SYNC_POS:
                            res.read_data = {1'b0, tim_cfg.v_sync_pos};
                        crtcvt_pkg::REG_SKEW:        res.read_data = skew_value;
                        crtcvt_pkg::REG_MAX_RASTER:  res.read_data = tim_cfg.max_raster;
                        crtcvt_pkg::REG_START_HI:
                            res.read_data = {2'b00, tim_cfg.start_addr[13:8]};
                        crtcvt_pkg::REG_START_LO:
                            res.read_data = tim_cfg.start_addr[7:0];
                        default:                     res.read_data = '0;
                    endcase
                end
            end
            default: ;
        endcase
        res.video.hsync       = hsync_on;
        res.video.vsync       = vsync_on;
        res.video.border      = border_on;
        res.video.mem_addr    = video_addr;
        res.video.raster_addr = scan_line;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // idle draws: mostly back to back, sometimes a gap up to the maximum
    // ------------------------------------------------------------------------
    function automatic int unsigned draw_wait();
        if (quiet_stretch)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(0, MAX_WAIT);
        return 0;
    endfunction

    // ------------------------------------------------------------------------
    // request driver: valid is lowered only when a gap follows, so it is
    // never dropped and raised in the same step
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [1:0] req, input logic [1:0] port,
                                input logic [7:0] data, input bit typed,
                                input crtcvt_pkg::t_result typed_want);
        int unsigned         gap;
        crtcvt_pkg::t_result model_res;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_port       <= port;
        i_write_data <= data;
        do @(posedge i_clk); while (!o_in_ready);
        // request taken at this edge, model steps in the same order
        model_res = crtc_timing_step(req, port, data);
        predicted_results.push_back(typed ? typed_want : model_res);
        requests_sent++;
    endtask

    task automatic send_plain(input logic [1:0] req, input logic [1:0] port,
                              input logic [7:0] data);
        send_request(req, port, data, 1'b0, '0);
    endtask

    task automatic add_row(input logic [1:0] req, input logic [1:0] port,
                           input logic [7:0] data, input bit typed,
                           input logic border, input logic [7:0] rd);
        t_bus_row row;
        row.req                = req;
        row.port               = port;
        row.data               = data;
        row.typed              = typed;
        row.want               = '0;
        row.want.video.border  = border;
        row.want.read_data     = rd;
        directed_rows.push_back(row);
    endtask

    // register index for the random part, unmapped ones included
    function automatic logic [7:0] pick_index();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 13));
    endfunction

    // small timing values keep frames short, a full byte now and then
    function automatic logic [7:0] pick_value(input logic [7:0] idx);
        logic [3:0] vw;
        logic [3:0] hw;
        if ($urandom_range(0, 15) == 0)
            return 8'($urandom_range(0, 255));
        case (idx)
            crtcvt_pkg::REG_H_TOTAL:     return 8'($urandom_range(2, 14));
            crtcvt_pkg::REG_H_DISPLAYED: return 8'($urandom_range(0, 14));
            crtcvt_pkg::REG_H_SYNC_POS:  return 8'($urandom_range(0, 14));
            crtcvt_pkg::REG_SYNC_WIDTH: begin
                vw = 4'($urandom_range(0, 4));
                hw = 4'($urandom_range(1, 6));
                return {vw, hw};
            end
            crtcvt_pkg::REG_V_TOTAL:     return 8'($urandom_range(0, 6));
            crtcvt_pkg::REG_V_ADJUST:    return 8'($urandom_range(0, 3));
            crtcvt_pkg::REG_V_DISPLAYED: return 8'($urandom_range(0, 6));
            crtcvt_pkg::REG_V_SYNC_POS:  return 8'($urandom_range(0, 6));
            crtcvt_pkg::REG_MAX_RASTER:  return 8'($urandom_range(0, 4));
            default:                     return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic program_reg(input logic [7:0] idx, input logic [7:0] data);
        send_plain(crtcvt_pkg::REQ_WRITE, crtcvt_pkg::PORT_INDEX, idx);
        send_plain(crtcvt_pkg::REQ_WRITE, crtcvt_pkg::PORT_DATA_WR, data);
    endtask

    // ------------------------------------------------------------------------
    // result side: random stall before each result, ready held until taken
    // ------------------------------------------------------------------------
    initial begin
        int unsigned stall;
        i_out_ready = 1'b0;
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic note_failure(input string what, input crtcvt_pkg::t_result want,
                                input crtcvt_pkg::t_result got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t %s: want hs=%b vs=%b bd=%b ma=%h ra=%0d rd=%h,",
                      " got hs=%b vs=%b bd=%b ma=%h ra=%0d rd=%h"},
                     $realtime, what,
                     want.video.hsync, want.video.vsync, want.video.border,
                     want.video.mem_addr, want.video.raster_addr, want.read_data,
                     got.video.hsync, got.video.vsync, got.video.border,
                     got.video.mem_addr, got.video.raster_addr, got.read_data);
    endtask

    // result checker, field by field against the oldest prediction
    always @(posedge i_clk) begin
        crtcvt_pkg::t_result got;
        crtcvt_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.video.hsync       = o_hsync;
            got.video.vsync       = o_vsync;
            got.video.border      = o_border;
            got.video.mem_addr    = o_mem_addr;
            got.video.raster_addr = o_raster_addr;
            got.read_data         = o_read_data;
            if (predicted_results.size() == 0) begin
                note_failure("result with no request outstanding", '0, got);
            end else begin
                want = predicted_results.pop_front();
                if (got.video.hsync       !== want.video.hsync       ||
                    got.video.vsync       !== want.video.vsync       ||
                    got.video.border      !== want.video.border      ||
                    got.video.mem_addr    !== want.video.mem_addr    ||
                    got.video.raster_addr !== want.video.raster_addr ||
                    got.read_data         !== want.read_data)
                    note_failure("result mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned choice;
        int unsigned burst;
        logic [7:0]  idx;
        t_bus_row    row;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_req_type     = crtcvt_pkg::REQ_TICK;
        i_port         = crtcvt_pkg::PORT_INDEX;
        i_write_data   = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        requests_sent  = 0;
        quiet_stretch  = 1'b0;
        model_reset();

        // after reset, bus only: video levels all zero, reads show reset values
        add_row(crtcvt_pkg::REQ_WRITE, crtcvt_pkg::PORT_INDEX, crtcvt_pkg::REG_H_TOTAL,
                1'b1, 1'b0, 8'd0);
        add_row(crtcvt_pkg::REQ_READ, crtcvt_pkg::PORT_DATA_RD, 8'h00,
                1'b1, 1'b0, crtcvt_pkg::RST_H_TOTAL);
        add_row(crtcvt_pkg::REQ_READ, crtcvt_pkg::PORT_STATUS, 8'h00,
                1'b1, 1'b0, 8'd0);
        add_row(crtcvt_pkg::REQ_READ, crtcvt_pkg::PORT_INDEX, 8'h00,
                1'b1, 1'b0, 8'd0);
        add_row(crtcvt_pkg::REQ_READ, crtcvt_pkg::PORT_DATA_WR, 8'h00,
                1'b1, 1'b0, 8'd0);
        // writes to status and data-read ports are dropped
        add_row(crtcvt_pkg::REQ_WRITE, crtcvt_pkg::PORT_STATUS, 8'hFF,
                1'b1, 1'b0, 8'd0);
        add_row(crtcvt_pkg::REQ_WRITE, crtcvt_pkg::PORT_DATA_RD, 8'hFF,
                1'b1, 1'b0, 8'd0);
        add_row(REQ_UNKNOWN, crtcvt_pkg::PORT_DATA_RD, 8'hFF,
                1'b1, 1'b0, 8'd0);
        add_row(crtcvt_pkg::REQ_READ, crtcvt_pkg::PORT_DATA_RD, 8'h00,
                1'b1, 1'b0, crtcvt_pkg::RST_H_TOTAL);
        // sync widths packed in one register, read does not disturb them
        add_row(crtcvt_pkg::REQ_WRITE, crtcvt_pkg::PORT_INDEX, crtcvt_pkg::REG_SYNC_WIDTH,
                1'b1, 1'b0, 8'd0);
        add_row(crtcvt_pkg::REQ_READ, crtcvt_pkg::PORT_DATA_RD, 8'h00, 1'b1, 1'b0,
                {crtcvt_pkg::RST_V_SYNC_WIDTH[3:0], crtcvt_pkg::RST_H_SYNC_WIDTH});
        // unmapped index: write dropped, read zero
        add_row(crtcvt_pkg::REQ_WRITE, crtcvt_pkg::PORT_INDEX, REG_UNMAPPED,
                1'b1, 1'b0, 8'd0);
        add_row(crtcvt_pkg::REQ_WRITE, crtcvt_pkg::PORT_DATA_WR, 8'hFF,
                1'b1, 1'b0, 8'd0);
        add_row(crtcvt_pkg::REQ_READ, crtcvt_pkg::PORT_DATA_RD, 8'h00,
                1'b1, 1'b0, 8'd0);
        // first tick leaves horizontal display off, so the border is up
        add_row(crtcvt_pkg::REQ_TICK, crtcvt_pkg::PORT_INDEX, 8'h00,
                1'b1, 1'b1, 8'd0);
        // zero width codes: 16-line vertical pulse, 256-char horizontal pulse
        add_row(crtcvt_pkg::REQ_WRITE, crtcvt_pkg::PORT_INDEX, crtcvt_pkg::REG_SYNC_WIDTH,
                1'b0, 1'b0, 8'd0);
        add_row(crtcvt_pkg::REQ_WRITE, crtcvt_pkg::PORT_DATA_WR, 8'h00,
                1'b0, 1'b0, 8'd0);
        add_row(crtcvt_pkg::REQ_READ, crtcvt_pkg::PORT_DATA_RD, 8'h00,
                1'b0, 1'b0, 8'd0);
        // max raster beyond the 5-bit line counter
        add_row(crtcvt_pkg::REQ_WRITE, crtcvt_pkg::PORT_INDEX, crtcvt_pkg::REG_MAX_RASTER,
                1'b0, 1'b0, 8'd0);
        add_row(crtcvt_pkg::REQ_WRITE, crtcvt_pkg::PORT_DATA_WR, 8'hFF,
                1'b0, 1'b0, 8'd0);
        add_row(crtcvt_pkg::REQ_READ, crtcvt_pkg::PORT_DATA_RD, 8'h00,
                1'b0, 1'b0, 8'd0);
        // start address high byte keeps only six bits
        add_row(crtcvt_pkg::REQ_WRITE, crtcvt_pkg::PORT_INDEX, crtcvt_pkg::REG_START_HI,
                1'b0, 1'b0, 8'd0);
        add_row(crtcvt_pkg::REQ_WRITE, crtcvt_pkg::PORT_DATA_WR, 8'hFF,
                1'b0, 1'b0, 8'd0);
        add_row(crtcvt_pkg::REQ_READ, crtcvt_pkg::PORT_DATA_RD, 8'h00,
                1'b0, 1'b0, 8'd0);
        add_row(crtcvt_pkg::REQ_TICK, crtcvt_pkg::PORT_DATA_RD, 8'hFF,
                1'b0, 1'b0, 8'd0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_request(row.req, row.port, row.data, row.typed, row.want);
        end

        // short frames first so that every counter turns over early
        for (int r = 0; r <= crtcvt_pkg::REG_START_LO; r++) begin
            idx = 8'(r);
            program_reg(idx, pick_value(idx));
        end

        requests_sent = 0;
        while (requests_sent < RANDOM_REQUESTS) begin
            if ($urandom_range(0, 15) == 0)
                quiet_stretch = ~quiet_stretch;
            choice = $urandom_range(0, 99);
            if (choice < 30) begin
                idx = pick_index();
                program_reg(idx, pick_value(idx));
            end else if (choice < 40) begin
                // read-back of a random register
                send_plain(crtcvt_pkg::REQ_WRITE, crtcvt_pkg::PORT_INDEX, pick_index());
                send_plain(crtcvt_pkg::REQ_READ, crtcvt_pkg::PORT_DATA_RD,
                           8'($urandom_range(0, 255)));
            end else if (choice < 48) begin
                // noise: any kind, any port, any byte
                burst = $urandom_range(1, 3);
                repeat (burst)
                    send_plain(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                               8'($urandom_range(0, 255)));
            end else begin
                burst = $urandom_range(10, 60);
                repeat (burst)
                    send_plain(crtcvt_pkg::REQ_TICK, 2'($urandom_range(0, 3)),
                               8'($urandom_range(0, 255)));
            end
        end

        // last request was taken at this edge, drop valid right away
        i_in_valid <= 1'b0;

        // drain, then a few more cycles to catch any stray result
        while (predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && predicted_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/crtcvt_pkg.sv
rtl/crtcvt_regs.sv
rtl/crtcvt_timing.sv
rtl/crtc_video_timing_top.sv
dv/crtc_video_timing_top_tb.sv
